/* rtl/core/smtp_env_pkg.sv */
// ----------------------------------------------------------------------------
// smtp_env_pkg
// shared types, constants and helpers of the smtp envelope address extractor
// ----------------------------------------------------------------------------
package smtp_env_pkg;

   // longest address kept; longer ones are truncated
   localparam int AddrMax    = 511;
   localparam int CountWidth = $clog2(AddrMax + 1);
   localparam int LenWidth   = 9;
   localparam int PosWidth   = 4;

   localparam logic [PosWidth-1:0] MailLen = PosWidth'(11);
   localparam logic [PosWidth-1:0] RcptLen = PosWidth'(9);

   localparam logic [7:0] CharCr    = 8'h0d;
   localparam logic [7:0] CharLf    = 8'h0a;
   localparam logic [7:0] CharUpM   = 8'h4d;
   localparam logic [7:0] CharUpR   = 8'h52;
   localparam logic [7:0] CharLowA  = 8'h61;
   localparam logic [7:0] CharLowZ  = 8'h7a;
   localparam logic [7:0] CaseShift = 8'h20;

   typedef enum logic [2:0] {
      MODE_START    = 3'd0,
      MODE_MAIL     = 3'd1,
      MODE_RCPT     = 3'd2,
      MODE_CAP_FROM = 3'd3,
      MODE_CAP_TO   = 3'd4,
      MODE_SKIP     = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_FROM_BYTE   = 3'd1,
      EV_TO_BYTE     = 3'd2,
      EV_FROM_COMMIT = 3'd3,
      EV_TO_COMMIT   = 3'd4,
      EV_ABORT       = 3'd5
   } event_type;

   // ascii lower case letters to upper case
   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      if (c >= CharLowA && c <= CharLowZ) begin
         return c - CaseShift;
      end
      return c;
   endfunction

   // expected character of "MAIL FROM: " at position p
   function automatic logic [7:0] mail_char(input logic [PosWidth-1:0] p);
      logic [7:0] c;
      case (p)
         4'd0:    c = 8'h4d; // M
         4'd1:    c = 8'h41; // A
         4'd2:    c = 8'h49; // I
         4'd3:    c = 8'h4c; // L
         4'd4:    c = 8'h20; // space
         4'd5:    c = 8'h46; // F
         4'd6:    c = 8'h52; // R
         4'd7:    c = 8'h4f; // O
         4'd8:    c = 8'h4d; // M
         4'd9:    c = 8'h3a; // colon
         4'd10:   c = 8'h20; // space
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // expected character of "RCPT TO: " at position p
   function automatic logic [7:0] rcpt_char(input logic [PosWidth-1:0] p);
      logic [7:0] c;
      case (p)
         4'd0:    c = 8'h52; // R
         4'd1:    c = 8'h43; // C
         4'd2:    c = 8'h50; // P
         4'd3:    c = 8'h54; // T
         4'd4:    c = 8'h20; // space
         4'd5:    c = 8'h54; // T
         4'd6:    c = 8'h4f; // O
         4'd7:    c = 8'h3a; // colon
         4'd8:    c = 8'h20; // space
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

/* rtl/core/smtp_envelope_address_extractor_top.sv */
// ----------------------------------------------------------------------------
// smtp_envelope_address_extractor_top
// picks MAIL FROM / RCPT TO envelope addresses out of an smtp byte stream
// ----------------------------------------------------------------------------
//
//  channel | ports                              | direction | handshake
//  --------+------------------------------------+-----------+---------------------
//  req     | payload_byte, packet_direction,    | in        | valid high, stall low
//          | last_of_packet                     |           |
//  rsp     | event_res, address_byte,           | out       | valid high, stall low
//          | address_length                     |           |
//  csr     | write_enable, write_data           | in        | write enable high
//
//  one request per cycle sustained while the response is not stalled; each
//  request yields exactly one response, via the input register, then the
//  response register, which holds it until taken; the parser state steps
//  when a request leaves the input register, so apart from a response stall
//  the rate is set only by the single compare-and-count step between the two
//  synchronous active-high reset clears the parser and both valid flags
//  a stalled response holds its register; the input register still takes
//  a request while empty or while the response register is free or being drained
//
module smtp_envelope_address_extractor_top (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_payload_byte,
   input  logic       req_packet_direction,
   input  logic       req_last_of_packet,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_res,
   output logic [7:0] rsp_address_byte,
   output logic [smtp_env_pkg::LenWidth-1:0] rsp_address_length,
   // configuration
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);

   localparam int CW = smtp_env_pkg::CountWidth;
   localparam int PW = smtp_env_pkg::PosWidth;
   localparam int LW = smtp_env_pkg::LenWidth;

   // configuration register
   logic ignored_dir_ff;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_dir_ff;
   logic       in_last_ff;

   // parser state
   smtp_env_pkg::mode_type mode_ff, mode_in;
   logic [PW-1:0]          pos_ff, pos_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   recip_ff, recip_in;

   // response register
   logic                    rsp_valid_ff;
   smtp_env_pkg::event_type rsp_event_ff, rsp_event_in;
   logic [7:0]              rsp_byte_ff, rsp_byte_in;
   logic [LW-1:0]           rsp_len_ff, rsp_len_in;

   // handshake control
   logic out_free;
   logic in_free;
   logic step;

   // working values of the request in the input register
   logic          active;
   logic [7:0]    upper;
   logic          is_term;
   logic          is_mail;
   logic [PW-1:0] plen;
   logic [7:0]    want;
   logic [PW-1:0] pos_next;
   logic          count_full;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign in_free   = !in_valid_ff || out_free;
   assign step      = in_valid_ff && out_free;
   assign req_stall = !in_free;

   assign active     = in_dir_ff != ignored_dir_ff;
   assign upper      = smtp_env_pkg::fold_upper(in_byte_ff);
   assign is_term    = (in_byte_ff == smtp_env_pkg::CharCr)
                    || (in_byte_ff == smtp_env_pkg::CharLf);
   assign is_mail    = mode_ff == smtp_env_pkg::MODE_MAIL;
   assign plen       = is_mail ? smtp_env_pkg::MailLen : smtp_env_pkg::RcptLen;
   assign want       = is_mail ? smtp_env_pkg::mail_char(pos_ff)
                               : smtp_env_pkg::rcpt_char(pos_ff);
   assign pos_next   = pos_ff + PW'(1);
   assign count_full = count_ff >= CW'(smtp_env_pkg::AddrMax);

   // next parser state
   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      recip_in = recip_ff;
      if (active) begin
         unique case (mode_ff)
            smtp_env_pkg::MODE_START: begin
               if (upper == smtp_env_pkg::CharUpM) begin
                  mode_in = smtp_env_pkg::MODE_MAIL;
                  pos_in  = PW'(1);
               end else if (upper == smtp_env_pkg::CharUpR && !recip_ff) begin
                  mode_in = smtp_env_pkg::MODE_RCPT;
                  pos_in  = PW'(1);
               end else begin
                  mode_in = smtp_env_pkg::MODE_SKIP;
               end
            end
            smtp_env_pkg::MODE_MAIL,
            smtp_env_pkg::MODE_RCPT: begin
               if (pos_ff >= plen || upper != want) begin
                  mode_in = smtp_env_pkg::MODE_SKIP;
               end else begin
                  pos_in = pos_next;
                  if (pos_next == plen) begin
                     mode_in  = is_mail ? smtp_env_pkg::MODE_CAP_FROM
                                        : smtp_env_pkg::MODE_CAP_TO;
                     count_in = '0;
                  end
               end
            end
            smtp_env_pkg::MODE_CAP_FROM,
            smtp_env_pkg::MODE_CAP_TO: begin
               if (is_term) begin
                  mode_in = smtp_env_pkg::MODE_SKIP;
                  if (mode_ff == smtp_env_pkg::MODE_CAP_FROM) begin
                     recip_in = 1'b0;
                  end else if (count_ff != '0) begin
                     recip_in = 1'b1;
                  end
               end else if (!in_last_ff && !count_full) begin
                  count_in = count_ff + CW'(1);
               end
            end
            default: begin
               mode_in = smtp_env_pkg::MODE_SKIP;
            end
         endcase
         // packet end in the active direction always re-arms the prefix match
         if (in_last_ff) begin
            mode_in = smtp_env_pkg::MODE_START;
            pos_in  = '0;
         end
      end
   end

   // response contents
   always_comb begin
      rsp_event_in = smtp_env_pkg::EV_NONE;
      rsp_byte_in  = '0;
      rsp_len_in   = '0;
      if (active) begin
         unique case (mode_ff)
            smtp_env_pkg::MODE_MAIL,
            smtp_env_pkg::MODE_RCPT: begin
               // prefix finished on the last byte: no terminator can follow
               if (pos_ff < plen && upper == want && pos_next == plen
                   && in_last_ff) begin
                  rsp_event_in = smtp_env_pkg::EV_ABORT;
               end
            end
            smtp_env_pkg::MODE_CAP_FROM,
            smtp_env_pkg::MODE_CAP_TO: begin
               if (is_term) begin
                  rsp_len_in   = LW'(count_ff);
                  rsp_event_in = (mode_ff == smtp_env_pkg::MODE_CAP_FROM)
                               ? smtp_env_pkg::EV_FROM_COMMIT
                               : smtp_env_pkg::EV_TO_COMMIT;
               end else if (in_last_ff) begin
                  rsp_event_in = smtp_env_pkg::EV_ABORT;
               end else if (!count_full) begin
                  rsp_byte_in  = in_byte_ff;
                  rsp_event_in = (mode_ff == smtp_env_pkg::MODE_CAP_FROM)
                               ? smtp_env_pkg::EV_FROM_BYTE
                               : smtp_env_pkg::EV_TO_BYTE;
               end
            end
            default: begin
               rsp_event_in = smtp_env_pkg::EV_NONE;
            end
         endcase
      end
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         ignored_dir_ff <= 1'b0;
      end else if (csr_write_enable) begin
         ignored_dir_ff <= csr_write_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_free) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_free && req_valid) begin
         in_byte_ff <= req_payload_byte;
         in_dir_ff  <= req_packet_direction;
         in_last_ff <= req_last_of_packet;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= smtp_env_pkg::MODE_START;
         pos_ff   <= '0;
         count_ff <= '0;
         recip_ff <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         recip_ff <= recip_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_event_ff <= rsp_event_in;
         rsp_byte_ff  <= rsp_byte_in;
         rsp_len_ff   <= rsp_len_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = rsp_event_ff;
   assign rsp_address_byte   = rsp_byte_ff;
   assign rsp_address_length = rsp_len_ff;

endmodule
